[design/rbc_pkg.sv]
// Shared types, constants and codes for the run-length byte compressor.
package rbc_pkg;

  // Build-time defaults for the top-level parameters
  localparam int MAX_BLOCK_DEF = 127;
  localparam int SIZE_BITS_DEF = 24;

  // Fixed field widths
  localparam int LANES      = 4;   // output bytes per result
  localparam int LANE_W     = 2;   // lane index width
  localparam int CNT_W      = 3;   // valid_bytes width
  localparam int LEN_W      = 7;   // block / run / literal counters (up to 127)
  localparam int CAP_W      = 24;  // out_capacity register width
  localparam int CFG_ADDR_W = 3;   // APB byte address width
  localparam int CFG_DATA_W = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = '1;
  localparam logic [7:0]       RUN_FLAG  = 8'h80;
  localparam logic [7:0]       ONE_LIT   = 8'h01;

  // Register index, taken from paddr[2]
  localparam logic CFG_IDX_OUT_CAPACITY = 1'b0;

  // Command queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = 1;
  localparam int Q_CNT_W = 2;

  // One flush command: optional literal span, optional run, optional
  // trailing single literal, plus the end-of-buffer mark.
  typedef struct packed {
    logic [LEN_W-1:0] lit_cnt;    // literal bytes, 0 when none
    logic [7:0]       lit_first;  // first literal (kept outside the store)
    logic             bank;       // store bank holding literals 1..n-1
    logic             run_en;
    logic [LEN_W-1:0] run_len;
    logic [7:0]       run_byte;
    logic             tail_en;    // one-byte literal block after the run
    logic [7:0]       tail_byte;
    logic             eob;
  } cmd_t;

  // Literal store write from the front
  typedef struct packed {
    logic             en;
    logic             bank;
    logic [LEN_W-1:0] addr;
    logic [7:0]       data;
  } lit_wr_t;

  // Bank release from the back
  typedef struct packed {
    logic valid;
    logic bank;
  } rel_t;

  // Byte descriptor between the sequencer and the packer
  typedef struct packed {
    logic       valid;
    logic       close;     // end of a command, no byte
    logic       from_mem;  // byte comes from the store read data
    logic       gate;      // literal count byte: opens a literal span
    logic       eob;
    logic [7:0] val;
  } desc_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_A_CNT,
    PH_A_LIT,
    PH_RUN_TOK,
    PH_RUN_BYTE,
    PH_T_CNT,
    PH_T_BYTE,
    PH_CLOSE
  } phase_t;

endpackage

[design/rbc_in_if.sv]
// Input byte channel: valid/ready with one raw byte and the end mark.
interface rbc_in_if import rbc_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_buffer;

  modport source (output valid, output data_byte, output end_of_buffer, input ready);
  modport sink   (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

[design/rbc_out_if.sv]
// Result channel: valid/ready with up to four packed bytes and the summary.
interface rbc_out_if import rbc_pkg::*; #(
  parameter int SIZE_BITS = SIZE_BITS_DEF
) ();
  logic                 valid;
  logic                 ready;
  logic [7:0]           lane0;
  logic [7:0]           lane1;
  logic [7:0]           lane2;
  logic [7:0]           lane3;
  logic [CNT_W-1:0]     valid_bytes;
  logic                 last_of_run;
  logic                 buffer_done;
  logic                 all_equal;
  logic                 overflow;
  logic [SIZE_BITS-1:0] compressed_size;

  modport source (
    output valid, output lane0, output lane1, output lane2, output lane3,
    output valid_bytes, output last_of_run, output buffer_done,
    output all_equal, output overflow, output compressed_size,
    input ready
  );
  modport sink (
    input valid, input lane0, input lane1, input lane2, input lane3,
    input valid_bytes, input last_of_run, input buffer_done,
    input all_equal, input overflow, input compressed_size,
    output ready
  );
endinterface

[design/rle_byte_compressor_top.sv]
// Run-length byte compressor: a front scans one input byte per cycle into
// blocks and queues flush commands; a back turns each command into count,
// literal and repeat bytes, checks them against out_capacity and packs them
// four to a result. Input bytes are taken at one per cycle while the command
// queue (two entries) has room and the literal bank being filled is free; the
// literal store has two banks, so a new block fills while the previous one
// drains. The back emits one byte per cycle through the single store read
// port unless a stalled result holds it; a flush of n literals plus a run
// sends a count byte, the n literals, a run token and the run byte, between
// an idle and a closing step per command. Each byte reaches the packer via
// a register. A full result is pushed when a byte arrives with four held,
// the remaining bytes at the close. A stalled result holds the back only;
// the front keeps scanning until the queue or both banks are occupied.
module rle_byte_compressor_top import rbc_pkg::*; #(
  parameter int MAX_BLOCK = MAX_BLOCK_DEF,
  parameter int SIZE_BITS = SIZE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  rbc_in_if.sink                in_chan,
  rbc_out_if.source             out_chan,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [CAP_W-1:0] cap_r;
  cmd_t             q_in;
  cmd_t             q_head;
  logic             q_push;
  logic             q_pop;
  logic             q_full;
  logic             q_empty;
  lit_wr_t          lit_wr;
  rel_t             rel;

  // Configuration register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == CFG_IDX_OUT_CAPACITY) ?
                  CFG_DATA_W'(cap_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == CFG_IDX_OUT_CAPACITY) begin
      cap_r <= pwdata[CAP_W-1:0];
    end
  end

  rbc_front #(
    .MAX_BLOCK (MAX_BLOCK)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .cmd      (q_in),
    .cmd_push (q_push),
    .q_full   (q_full),
    .lit_wr   (lit_wr),
    .rel      (rel)
  );

  rbc_cmd_fifo u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_in),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_head),
    .empty (q_empty)
  );

  rbc_back #(
    .MAX_BLOCK (MAX_BLOCK),
    .SIZE_BITS (SIZE_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (q_head),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .lit_wr   (lit_wr),
    .rel      (rel),
    .cap      (cap_r),
    .out_chan (out_chan)
  );

endmodule

[design/rbc_front.sv]
// Front end: greedy block scan, literal store writes, flush command issue.
module rbc_front import rbc_pkg::*; #(
  parameter int MAX_BLOCK = MAX_BLOCK_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  rbc_in_if.sink     in_chan,
  output cmd_t       cmd,
  output logic       cmd_push,
  input  logic       q_full,
  output lit_wr_t    lit_wr,
  input  rel_t       rel
);

  localparam logic [LEN_W-1:0] MAX_LEN   = LEN_W'(MAX_BLOCK);
  localparam logic             RUN2_FULL = (MAX_BLOCK <= 2);

  logic [LEN_W-1:0] blen_r, blen_nxt;
  logic [LEN_W-1:0] rso_r, rso_nxt;
  logic             run_r, run_nxt;
  logic [7:0]       prev_r, prev_nxt;
  logic [7:0]       first_r, first_nxt;
  logic             bank_r, bank_nxt;
  logic [1:0]       busy_r, busy_nxt;

  logic             accept;
  logic             flush;
  logic             restart;
  logic [LEN_W-1:0] blen_inc;
  logic [7:0]       b;
  logic             eob;

  // Collect only into a bank that the back is no longer reading
  assign in_chan.ready = !q_full && !busy_r[bank_r];
  assign accept        = in_chan.valid && in_chan.ready;
  assign b             = in_chan.data_byte;
  assign eob           = in_chan.end_of_buffer;
  assign blen_inc      = blen_r + LEN_W'(1);

  // Scan step
  always_comb begin
    blen_nxt  = blen_r;
    rso_nxt   = rso_r;
    run_nxt   = run_r;
    prev_nxt  = prev_r;
    first_nxt = first_r;
    bank_nxt  = bank_r;
    busy_nxt  = busy_r;
    flush     = 1'b0;
    restart   = 1'b0;
    cmd_push  = 1'b0;

    cmd           = '0;
    cmd.lit_first = first_r;
    cmd.bank      = bank_r;
    cmd.run_byte  = prev_r;

    lit_wr      = '0;
    lit_wr.bank = bank_r;
    lit_wr.addr = blen_r;
    lit_wr.data = b;

    if (rel.valid) begin
      busy_nxt[rel.bank] = 1'b0;
    end

    if (accept) begin
      if (blen_r == '0) begin
        // Open a new block
        first_nxt = b;
        prev_nxt  = b;
        blen_nxt  = LEN_W'(1);
        rso_nxt   = '0;
        run_nxt   = 1'b0;
        if (eob) begin
          cmd.lit_cnt   = LEN_W'(1);
          cmd.lit_first = b;
          flush         = 1'b1;
        end
      end else if (run_r) begin
        if (b == prev_r) begin
          // Run grows
          blen_nxt = blen_inc;
          if (blen_inc >= MAX_LEN || eob) begin
            cmd.lit_cnt = rso_r;
            cmd.run_en  = 1'b1;
            cmd.run_len = blen_inc;
            flush       = 1'b1;
          end
        end else begin
          // Run broken: flush it and open a block with this byte
          cmd.lit_cnt   = rso_r;
          cmd.run_en    = 1'b1;
          cmd.run_len   = blen_r;
          flush         = 1'b1;
          restart       = 1'b1;
          first_nxt     = b;
          prev_nxt      = b;
          cmd.tail_en   = eob;
          cmd.tail_byte = b;
        end
      end else if (b == prev_r) begin
        // Last literal and this byte start a run
        run_nxt  = 1'b1;
        rso_nxt  = blen_r - LEN_W'(1);
        blen_nxt = LEN_W'(2);
        if (RUN2_FULL || eob) begin
          cmd.lit_cnt = blen_r - LEN_W'(1);
          cmd.run_en  = 1'b1;
          cmd.run_len = LEN_W'(2);
          flush       = 1'b1;
        end
      end else begin
        // Another literal
        lit_wr.en = 1'b1;
        blen_nxt  = blen_inc;
        prev_nxt  = b;
        if (blen_inc >= MAX_LEN || eob) begin
          cmd.lit_cnt = blen_inc;
          flush       = 1'b1;
        end
      end

      if (flush) begin
        blen_nxt = restart ? LEN_W'(1) : '0;
        rso_nxt  = '0;
        run_nxt  = 1'b0;
        // Literals beyond the first live in the bank: hand it over
        if (cmd.lit_cnt >= LEN_W'(2)) begin
          bank_nxt         = ~bank_r;
          busy_nxt[bank_r] = 1'b1;
        end
      end

      if (eob) begin
        blen_nxt = '0;
        rso_nxt  = '0;
        run_nxt  = 1'b0;
        prev_nxt = '0;
      end

      cmd.eob  = eob;
      cmd_push = flush || eob;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blen_r  <= '0;
      rso_r   <= '0;
      run_r   <= 1'b0;
      prev_r  <= '0;
      first_r <= '0;
      bank_r  <= 1'b0;
      busy_r  <= '0;
    end else begin
      blen_r  <= blen_nxt;
      rso_r   <= rso_nxt;
      run_r   <= run_nxt;
      prev_r  <= prev_nxt;
      first_r <= first_nxt;
      bank_r  <= bank_nxt;
      busy_r  <= busy_nxt;
    end
  end

endmodule

[design/rbc_cmd_fifo.sv]
// Two-entry command queue between the scan front and the output back.
module rbc_cmd_fifo import rbc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t din,
  output logic full,
  input  logic pop,
  output cmd_t dout,
  output logic empty
);

  cmd_t               slot_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r;
  logic [Q_PTR_W-1:0] rd_ptr_r;
  logic [Q_CNT_W-1:0] count_r;

  assign full  = (count_r == Q_CNT_W'(Q_DEPTH));
  assign empty = (count_r == '0);
  assign dout  = slot_r[rd_ptr_r];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= din;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + Q_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + Q_PTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + Q_CNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - Q_CNT_W'(1);
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full || pop)
    else $error("command pushed into a full queue");
`endif

endmodule

[design/rbc_back.sv]
// Back end: literal store, byte sequencer, capacity check and lane packer.
module rbc_back import rbc_pkg::*; #(
  parameter int MAX_BLOCK = MAX_BLOCK_DEF,
  parameter int SIZE_BITS = SIZE_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  cmd_t             cmd,
  input  logic             q_empty,
  output logic             q_pop,
  input  lit_wr_t          lit_wr,
  output rel_t             rel,
  input  logic [CAP_W-1:0] cap,
  rbc_out_if.source        out_chan
);

  localparam int IDX_W = $clog2(MAX_BLOCK);
  localparam int CMP_W = (SIZE_BITS > CAP_W) ? SIZE_BITS : CAP_W;

  // Literal store, one bank per block in flight
  logic [7:0] lit_mem [2][MAX_BLOCK];
  logic [7:0] rd_data_r;
  logic       rd_en;

  // Sequencer
  phase_t           phase_r, phase_nxt;
  logic [LEN_W-1:0] idx_r, idx_nxt;
  desc_t            desc_g;
  desc_t            d_r;
  phase_t           after_lit;
  phase_t           after_run;

  // Packer and buffer totals
  logic [7:0]           acc_r [LANES];
  logic [7:0]           acc_nxt [LANES];
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [SIZE_BITS-1:0] bw_r, bw_nxt;
  logic                 ovf_r, ovf_nxt;
  logic                 ae_r, ae_nxt;
  logic [7:0]           bval;
  logic                 room;
  logic                 push;
  logic                 push_last;
  logic                 push_done;
  logic                 adv;

  // Output register
  logic                 out_valid_r;
  logic [7:0]           out_lane_r [LANES];
  logic [CNT_W-1:0]     out_cnt_r;
  logic                 out_last_r;
  logic                 out_done_r;
  logic                 out_ae_r;
  logic                 out_ovf_r;
  logic [SIZE_BITS-1:0] out_size_r;

  // Store write port
  always_ff @(posedge clk) begin
    if (lit_wr.en) begin
      lit_mem[lit_wr.bank][lit_wr.addr[IDX_W-1:0]] <= lit_wr.data;
    end
  end

  // Store read port, held while the packer stalls
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= lit_mem[cmd.bank][idx_r[IDX_W-1:0]];
    end
  end

  // Sequencer: one byte descriptor per cycle from the queue head, unless the packer stalls
  always_comb begin
    phase_nxt = phase_r;
    idx_nxt   = idx_r;
    desc_g    = '0;
    rd_en     = 1'b0;
    q_pop     = 1'b0;
    rel       = '0;
    rel.bank  = cmd.bank;
    after_lit = cmd.run_en ? PH_RUN_TOK : (cmd.tail_en ? PH_T_CNT : PH_CLOSE);
    after_run = cmd.tail_en ? PH_T_CNT : PH_CLOSE;

    unique case (phase_r)
      PH_IDLE: begin
        if (!q_empty) begin
          phase_nxt = (cmd.lit_cnt != '0) ? PH_A_CNT : after_lit;
        end
      end
      PH_A_CNT: begin
        desc_g.valid = 1'b1;
        desc_g.gate  = 1'b1;
        desc_g.val   = 8'(cmd.lit_cnt);
        idx_nxt      = '0;
        phase_nxt    = PH_A_LIT;
      end
      PH_A_LIT: begin
        desc_g.valid = 1'b1;
        if (idx_r == '0) begin
          desc_g.val = cmd.lit_first;
        end else begin
          desc_g.from_mem = 1'b1;
          rd_en           = 1'b1;
        end
        if (idx_r == cmd.lit_cnt - LEN_W'(1)) begin
          phase_nxt = after_lit;
        end else begin
          idx_nxt = idx_r + LEN_W'(1);
        end
      end
      PH_RUN_TOK: begin
        desc_g.valid = 1'b1;
        desc_g.val   = RUN_FLAG | 8'(cmd.run_len);
        phase_nxt    = PH_RUN_BYTE;
      end
      PH_RUN_BYTE: begin
        desc_g.valid = 1'b1;
        desc_g.val   = cmd.run_byte;
        phase_nxt    = after_run;
      end
      PH_T_CNT: begin
        desc_g.valid = 1'b1;
        desc_g.gate  = 1'b1;
        desc_g.val   = ONE_LIT;
        phase_nxt    = PH_T_BYTE;
      end
      PH_T_BYTE: begin
        desc_g.valid = 1'b1;
        desc_g.val   = cmd.tail_byte;
        phase_nxt    = PH_CLOSE;
      end
      PH_CLOSE: begin
        desc_g.valid = 1'b1;
        desc_g.close = 1'b1;
        desc_g.eob   = cmd.eob;
        q_pop        = 1'b1;
        rel.valid    = (cmd.lit_cnt >= LEN_W'(2));
        phase_nxt    = PH_IDLE;
      end
    endcase

    // Freeze everything while the packer waits on the output register
    if (!adv) begin
      phase_nxt = phase_r;
      idx_nxt   = idx_r;
      rd_en     = 1'b0;
      q_pop     = 1'b0;
      rel.valid = 1'b0;
    end
  end

  // Packer: capacity check per byte, four bytes per result
  assign bval = d_r.from_mem ? rd_data_r : d_r.val;
  assign room = (CMP_W'(bw_r) < CMP_W'(cap)) && (bw_r != '1);

  always_comb begin
    acc_nxt   = acc_r;
    cnt_nxt   = cnt_r;
    bw_nxt    = bw_r;
    ovf_nxt   = ovf_r;
    ae_nxt    = ae_r;
    push      = 1'b0;
    push_last = 1'b0;
    push_done = 1'b0;

    if (d_r.valid) begin
      if (d_r.close) begin
        if (cnt_r != '0 || d_r.eob) begin
          push      = 1'b1;
          push_last = 1'b1;
          push_done = d_r.eob;
        end
        cnt_nxt = '0;
        if (d_r.eob) begin
          bw_nxt  = '0;
          ovf_nxt = 1'b0;
          ae_nxt  = 1'b1;
        end
      end else if (!ovf_r) begin
        // A literal span that starts before overflow counts even if cut
        if (d_r.gate) begin
          ae_nxt = 1'b0;
        end
        if (room) begin
          bw_nxt = bw_r + SIZE_BITS'(1);
          if (cnt_r == CNT_W'(LANES)) begin
            push       = 1'b1;
            acc_nxt[0] = bval;
            cnt_nxt    = CNT_W'(1);
          end else begin
            acc_nxt[cnt_r[LANE_W-1:0]] = bval;
            cnt_nxt                    = cnt_r + CNT_W'(1);
          end
        end else begin
          ovf_nxt = 1'b1;
        end
      end
    end
  end

  assign adv = !(push && out_valid_r && !out_chan.ready);

  // Sequencer and packer registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      idx_r   <= '0;
      d_r     <= '0;
      cnt_r   <= '0;
      bw_r    <= '0;
      ovf_r   <= 1'b0;
      ae_r    <= 1'b1;
    end else if (adv) begin
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
      d_r     <= desc_g;
      cnt_r   <= cnt_nxt;
      bw_r    <= bw_nxt;
      ovf_r   <= ovf_nxt;
      ae_r    <= ae_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      acc_r <= acc_nxt;
    end
  end

  // Output register control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (push && adv) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output register payload; unused lanes read as zero
  always_ff @(posedge clk) begin
    if (push && adv) begin
      for (int j = 0; j < LANES; j++) begin
        out_lane_r[j] <= (CNT_W'(j) < cnt_r) ? acc_r[j] : 8'h00;
      end
      out_cnt_r  <= cnt_r;
      out_last_r <= push_last;
      out_done_r <= push_done;
      out_ae_r   <= push_done && ae_r;
      out_ovf_r  <= push_done && ovf_r;
      out_size_r <= push_done ? bw_r : '0;
    end
  end

  assign out_chan.valid           = out_valid_r;
  assign out_chan.lane0           = out_lane_r[0];
  assign out_chan.lane1           = out_lane_r[1];
  assign out_chan.lane2           = out_lane_r[2];
  assign out_chan.lane3           = out_lane_r[3];
  assign out_chan.valid_bytes     = out_cnt_r;
  assign out_chan.last_of_run     = out_last_r;
  assign out_chan.buffer_done     = out_done_r;
  assign out_chan.all_equal       = out_ae_r;
  assign out_chan.overflow        = out_ovf_r;
  assign out_chan.compressed_size = out_size_r;

`ifndef NO_ASSERTIONS
  a_full_unless_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_last_r |-> out_cnt_r == CNT_W'(LANES))
    else $error("non-final result is not full");

  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_done_r |-> out_last_r)
    else $error("buffer summary on a non-final result");

  a_summary_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_done_r |-> !out_ae_r && !out_ovf_r && out_size_r == '0)
    else $error("summary fields set outside buffer end");

  a_buffer_clear: assert property (@(posedge clk) disable iff (!rst_n)
    adv && d_r.valid && d_r.close && d_r.eob |=> bw_r == '0 && ae_r && !ovf_r)
    else $error("buffer totals not cleared after buffer end");

  a_close_has_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r != PH_IDLE |-> !q_empty)
    else $error("sequencer active with an empty command queue");
`endif

endmodule

[tb/testbench.sv]
// Self-checking testbench for the run-length byte compressor: directed and random buffers.
module testbench;
  import rbc_pkg::*;

  localparam int SETTLE_CYCLES = 600;  // back drain after the last result
  localparam int HOLD_CYCLES   = 500;  // long receiver hold-off
  localparam int MAX_REPORTS   = 40;
  localparam int RANDOM_ITEMS  = 72;
  localparam int STALL_ITEMS   = 24;
  localparam logic [CFG_ADDR_W-1:0] ADDR_OUT_CAPACITY = {CFG_IDX_OUT_CAPACITY, 2'b00};
  localparam logic [CAP_W-1:0]      CAP_MAX           = '1;

  // One result transaction as seen on the output channel
  typedef struct packed {
    logic [7:0]       lane0;
    logic [7:0]       lane1;
    logic [7:0]       lane2;
    logic [7:0]       lane3;
    logic [CNT_W-1:0] nbytes;
    logic             last;
    logic             done;
    logic             alleq;
    logic             ovf;
    logic [CAP_W-1:0] size;
  } out_word_t;

  logic                  clk      = 1'b0;
  logic                  rst_n    = 1'b0;
  logic                  psel     = 1'b0;
  logic                  penable  = 1'b0;
  logic                  pwrite   = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr    = '0;
  logic [CFG_DATA_W-1:0] pwdata   = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  rx_ready = 1'b0;

  rbc_in_if in_ch();
  rbc_out_if #(.SIZE_BITS(SIZE_BITS_DEF)) out_ch();

  assign out_ch.ready = rx_ready;

  rle_byte_compressor_top #(
    .MAX_BLOCK(MAX_BLOCK_DEF),
    .SIZE_BITS(SIZE_BITS_DEF)
  ) i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_ch),
    .out_chan(out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Idle rates, hold-off request and bookkeeping
  int unsigned snd_idle_pct   = 19;
  int unsigned rcv_idle_pct   = 58;
  int unsigned hold_seq       = 0;
  int unsigned hold_seen      = 0;
  int unsigned hold_left      = 0;
  int unsigned items_sent     = 0;
  int unsigned mismatch_count = 0;
  int unsigned readback_errs  = 0;

  // Encoder model state
  logic [7:0]       lit_mem [0:MAX_BLOCK_DEF-1];
  int unsigned      blk_len    = 0;
  int unsigned      run_base   = 0;
  logic             in_run     = 1'b0;
  logic [7:0]       last_byte  = 8'h00;
  logic [CAP_W-1:0] bytes_out  = '0;
  logic             cap_hit    = 1'b0;
  logic             no_literal = 1'b1;
  logic [CAP_W-1:0] capacity_q = CAP_MAX;
  logic [7:0]       emitted [$];
  out_word_t        pending_words [$];

  // One compressed byte, subject to the capacity
  function void put_out(logic [7:0] v);
    if (cap_hit) return;
    if (bytes_out < capacity_q) begin
      emitted.push_back(v);
      bytes_out = bytes_out + 1'b1;
    end else begin
      cap_hit = 1'b1;
    end
  endfunction

  function void put_literal_span(int unsigned n);
    put_out(8'(n));
    for (int unsigned i = 0; i < n && i < MAX_BLOCK_DEF; i++) put_out(lit_mem[i]);
    no_literal = 1'b0;
  endfunction

  // Emit the pending block: literals, optional run token and run byte
  function void close_block();
    if (blk_len != 0 && !cap_hit) begin
      if (in_run) begin
        if (run_base > 0) put_literal_span(run_base);
        put_out(RUN_FLAG | 8'(blk_len & 32'h7F));
        put_out(last_byte);
      end else begin
        put_literal_span(blk_len);
      end
    end
    blk_len  = 0;
    run_base = 0;
    in_run   = 1'b0;
  endfunction

  function void open_block(logic [7:0] b);
    lit_mem[0] = b;
    last_byte  = b;
    blk_len    = 1;
    run_base   = 0;
    in_run     = 1'b0;
  endfunction

  function logic [7:0] lane_at(int unsigned idx);
    return (idx < emitted.size()) ? emitted[idx] : 8'h00;
  endfunction

  // Scan one input byte and queue the result transactions it causes
  function void predict_byte(logic [7:0] b, logic eob);
    int unsigned nres;
    int unsigned base;
    int unsigned cnt;
    out_word_t   w;
    emitted.delete();
    if (blk_len == 0) begin
      open_block(b);
    end else if (in_run) begin
      if (b == last_byte) begin
        blk_len++;
        if (blk_len >= MAX_BLOCK_DEF) close_block();
      end else begin
        close_block();
        open_block(b);
      end
    end else if (b == last_byte) begin
      in_run   = 1'b1;
      run_base = blk_len - 1;
      blk_len  = 2;
      if (blk_len >= MAX_BLOCK_DEF) close_block();
    end else begin
      if (blk_len < MAX_BLOCK_DEF) lit_mem[blk_len] = b;
      blk_len++;
      last_byte = b;
      if (blk_len >= MAX_BLOCK_DEF) close_block();
    end
    if (eob) close_block();

    nres = (emitted.size() + LANES - 1) / LANES;
    if (eob && nres == 0) nres = 1;
    for (int unsigned k = 0; k < nres; k++) begin
      base = k * LANES;
      cnt  = (emitted.size() > base) ? emitted.size() - base : 0;
      if (cnt > LANES) cnt = LANES;
      w        = '0;
      w.lane0  = lane_at(base);
      w.lane1  = lane_at(base + 1);
      w.lane2  = lane_at(base + 2);
      w.lane3  = lane_at(base + 3);
      w.nbytes = CNT_W'(cnt);
      w.last   = (k + 1 == nres);
      if (w.last && eob) begin
        w.done  = 1'b1;
        w.alleq = no_literal;
        w.ovf   = cap_hit;
        w.size  = bytes_out;
      end
      pending_words.push_back(w);
    end

    // Buffer end returns the scan to its reset state
    if (eob) begin
      blk_len    = 0;
      run_base   = 0;
      in_run     = 1'b0;
      last_byte  = 8'h00;
      bytes_out  = '0;
      cap_hit    = 1'b0;
      no_literal = 1'b1;
    end
  endfunction

  task automatic report_field(string name, logic [31:0] e, logic [31:0] g);
    if (e !== g) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
        $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, e, g);
    end
  endtask

  // Result checker and receiver idling
  always @(posedge clk) begin
    out_word_t got;
    out_word_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.lane0  = out_ch.lane0;
      got.lane1  = out_ch.lane1;
      got.lane2  = out_ch.lane2;
      got.lane3  = out_ch.lane3;
      got.nbytes = out_ch.valid_bytes;
      got.last   = out_ch.last_of_run;
      got.done   = out_ch.buffer_done;
      got.alleq  = out_ch.all_equal;
      got.ovf    = out_ch.overflow;
      got.size   = out_ch.compressed_size;
      if (pending_words.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("%0t: unexpected transaction: expected none, actual %0h", $time, got);
      end else begin
        want = pending_words.pop_front();
        report_field("lane0", want.lane0, got.lane0);
        report_field("lane1", want.lane1, got.lane1);
        report_field("lane2", want.lane2, got.lane2);
        report_field("lane3", want.lane3, got.lane3);
        report_field("valid_bytes", want.nbytes, got.nbytes);
        report_field("last_of_run", want.last, got.last);
        report_field("buffer_done", want.done, got.done);
        report_field("all_equal", want.alleq, got.alleq);
        report_field("overflow", want.ovf, got.ovf);
        report_field("compressed_size", want.size, got.size);
      end
    end
    if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      rx_ready <= 1'b0;
      hold_left--;
    end else begin
      rx_ready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // One input transaction, with random idle cycles ahead of it
  task automatic send_byte(logic [7:0] b, logic eob);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.data_byte     <= b;
    in_ch.end_of_buffer <= eob;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    predict_byte(b, eob);
    items_sent++;
  endtask

  task automatic send_buffer(logic [7:0] q[$]);
    for (int i = 0; i < q.size(); i++) send_byte(q[i], i == q.size() - 1);
  endtask

  // Stop sending, let every expected result arrive, then let the back go quiet
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_read(logic [CFG_ADDR_W-1:0] a, output logic [CFG_DATA_W-1:0] rd);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= a;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Register write followed by a read-back check
  task automatic cfg_write(logic [CFG_ADDR_W-1:0] a, logic [CFG_DATA_W-1:0] d);
    logic [CFG_DATA_W-1:0] rd;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= a;
    pwdata  <= d;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (a == ADDR_OUT_CAPACITY) capacity_q = d[CAP_W-1:0];
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    cfg_read(a, rd);
    if (rd !== CFG_DATA_W'(capacity_q)) begin
      readback_errs++;
      $display("%0t: out_capacity read-back: expected %0h, actual %0h",
               $time, CFG_DATA_W'(capacity_q), rd);
    end
  endtask

  task automatic test_register_reset();
    logic [CFG_DATA_W-1:0] rd;
    cfg_read(ADDR_OUT_CAPACITY, rd);
    if (rd !== CFG_DATA_W'(CAP_MAX)) begin
      readback_errs++;
      $display("%0t: out_capacity after reset: expected %0h, actual %0h",
               $time, CFG_DATA_W'(CAP_MAX), rd);
    end
    @(posedge clk);
  endtask

  // One-byte buffers at both byte extremes
  task automatic test_single_bytes();
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    wait_idle();
  endtask

  // Pure run, literals ahead of a run, and a lone byte after a run
  task automatic test_runs_and_literals();
    send_byte(8'hAA, 1'b0);
    send_byte(8'hAA, 1'b1);
    send_byte(8'h01, 1'b0);
    send_byte(8'h02, 1'b0);
    send_byte(8'h03, 1'b0);
    send_byte(8'h03, 1'b1);
    send_byte(8'h55, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'h56, 1'b1);
    wait_idle();
  endtask

  // Zero capacity drops everything; a capacity met exactly does not overflow
  task automatic test_capacity_limits();
    cfg_write(ADDR_OUT_CAPACITY, '0);
    send_byte(8'h5A, 1'b0);
    send_byte(8'h5A, 1'b0);
    send_byte(8'h3C, 1'b1);
    wait_idle();
    cfg_write(ADDR_OUT_CAPACITY, CFG_DATA_W'(2));
    send_byte(8'h77, 1'b0);
    send_byte(8'h77, 1'b1);
    wait_idle();
    cfg_write(ADDR_OUT_CAPACITY, CFG_DATA_W'(CAP_MAX));
  endtask

  // Capacity lowered below the bytes already written, in mid-buffer
  task automatic test_capacity_lowered_mid_buffer();
    send_byte(8'h10, 1'b0);
    send_byte(8'h10, 1'b0);
    send_byte(8'h20, 1'b0);
    wait_idle();
    cfg_write(ADDR_OUT_CAPACITY, CFG_DATA_W'(1));
    send_byte(8'h30, 1'b0);
    send_byte(8'h30, 1'b1);
    wait_idle();
    cfg_write(ADDR_OUT_CAPACITY, CFG_DATA_W'(CAP_MAX));
  endtask

  // Literal span and run that both reach the block limit
  task automatic test_max_blocks();
    logic [7:0] q[$];
    for (int i = 0; i < MAX_BLOCK_DEF; i++) q.push_back(8'(i));
    repeat (MAX_BLOCK_DEF) q.push_back(8'hC3);
    send_buffer(q);
    wait_idle();
  endtask

  // Receiver held off while the sender keeps offering short runs
  task automatic test_input_stall();
    logic [7:0] q[$];
    snd_idle_pct = 0;
    for (int i = 0; i < STALL_ITEMS; i++) q.push_back(8'((i / 2) * 3));
    hold_seq++;
    send_buffer(q);
    wait_idle();
  endtask

  // Random buffer: runs, byte ramps, random bytes and two-value noise
  task automatic send_random_buffer(int unsigned max_len);
    logic [7:0]  q[$];
    logic [7:0]  b;
    int unsigned target;
    int unsigned seg;
    target = $urandom_range(1, 14);
    if (target > max_len) target = max_len;
    while (q.size() < target) begin
      b = 8'($urandom);
      case ($urandom_range(3))
        0: begin
          seg = $urandom_range(2, 6);
          repeat (seg) q.push_back(b);
        end
        1: begin
          seg = $urandom_range(1, 6);
          repeat (seg) begin
            q.push_back(b);
            b = b + 8'd1;
          end
        end
        2: begin
          repeat ($urandom_range(1, 6)) q.push_back(8'($urandom));
        end
        default: begin
          repeat ($urandom_range(1, 8)) q.push_back($urandom_range(1) ? 8'hFF : 8'h00);
        end
      endcase
    end
    while (q.size() > target) void'(q.pop_back());
    send_buffer(q);
  endtask

  task automatic pick_capacity();
    logic [CFG_DATA_W-1:0] cap;
    case ($urandom_range(5))
      0:       cap = '0;
      1, 2:    cap = CFG_DATA_W'(CAP_MAX);
      3, 4:    cap = CFG_DATA_W'($urandom_range(1, 40));
      default: cap = CFG_DATA_W'($urandom_range(41, CAP_MAX));
    endcase
    wait_idle();
    cfg_write(ADDR_OUT_CAPACITY, cap);
  endtask

  // Three idling regimes, capacity changed between buffers
  task automatic test_random();
    int unsigned start;
    int unsigned phase_end;
    start = items_sent;
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0:       begin snd_idle_pct = 19; rcv_idle_pct = 58; end
        1:       begin snd_idle_pct = 58; rcv_idle_pct = 19; end
        default: begin snd_idle_pct = 0;  rcv_idle_pct = 0;  end
      endcase
      phase_end = start + (ph + 1) * RANDOM_ITEMS / 3;
      while (items_sent < phase_end) begin
        if ($urandom_range(4) == 0) pick_capacity();
        send_random_buffer(phase_end - items_sent);
      end
    end
    wait_idle();
    cfg_write(ADDR_OUT_CAPACITY, CFG_DATA_W'(CAP_MAX));
  endtask

  initial begin
    in_ch.valid         <= 1'b0;
    in_ch.data_byte     <= 8'h00;
    in_ch.end_of_buffer <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_register_reset();
    test_single_bytes();
    test_runs_and_literals();
    test_capacity_limits();
    test_capacity_lowered_mid_buffer();
    test_max_blocks();
    test_input_stall();
    test_random();
    wait_idle();
    if (mismatch_count == 0 && readback_errs == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Run limit
  initial begin
    #3000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
